>>> rtl/nmea_chk_pkg.sv
// ----------------------------------------------------------------------------
// nmea_chk_pkg
// Shared types and codes of the sentence checksum checker: the classified
// byte token passed from front to back, and the line status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_chk_pkg;

   // line status codes
   localparam logic [2:0] StatusOk       = 3'd0;
   localparam logic [2:0] StatusNoDollar = 3'd1;
   localparam logic [2:0] StatusNoStar   = 3'd2;
   localparam logic [2:0] StatusMismatch = 3'd3;
   localparam logic [2:0] StatusNoHex    = 3'd4;
   localparam logic [2:0] StatusTooLong  = 3'd5;

   // characters of interest
   localparam logic [7:0] CharNewline = 8'h0a;
   localparam logic [7:0] CharDollar  = 8'h24;
   localparam logic [7:0] CharStar    = 8'h2a;

   // request queue between front and back
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   // one classified byte
   typedef struct packed {
      logic       is_newline;
      logic       is_dollar;
      logic       is_star;
      logic       is_hex;
      logic [3:0] hex_digit;
      logic [7:0] data;
   } token_type;

endpackage

`default_nettype wire

>>> rtl/nmea_chk_front.sv
// ----------------------------------------------------------------------------
// nmea_chk_front
// Classifies each incoming byte: newline, dollar, star, hex digit and value.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_chk_front (
   input  wire logic [7:0]             byte_in,
   output nmea_chk_pkg::token_type     token
);

   logic       digit_num;
   logic       digit_upper;
   logic       digit_lower;
   logic [7:0] digit_off;

   always_comb begin
      digit_num   = (byte_in >= 8'h30) && (byte_in <= 8'h39);
      digit_upper = (byte_in >= 8'h41) && (byte_in <= 8'h46);
      digit_lower = (byte_in >= 8'h61) && (byte_in <= 8'h66);

      // value of the digit in its range
      priority if (digit_num) begin
         digit_off = byte_in - 8'h30;
      end else if (digit_upper) begin
         digit_off = byte_in - 8'h37;
      end else if (digit_lower) begin
         digit_off = byte_in - 8'h57;
      end else begin
         digit_off = 8'h00;
      end

      token.is_newline = (byte_in == nmea_chk_pkg::CharNewline);
      token.is_dollar  = (byte_in == nmea_chk_pkg::CharDollar);
      token.is_star    = (byte_in == nmea_chk_pkg::CharStar);
      token.is_hex     = digit_num || digit_upper || digit_lower;
      token.hex_digit  = digit_off[3:0];
      token.data       = byte_in;
   end

endmodule

`default_nettype wire

>>> rtl/nmea_chk_queue.sv
// ----------------------------------------------------------------------------
// nmea_chk_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_chk_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire nmea_chk_pkg::token_type push_token,
   output logic                         full,
   output logic                         not_empty,
   input  wire logic                    pop,
   output nmea_chk_pkg::token_type      head_token
);

   nmea_chk_pkg::token_type                    entry_ff [nmea_chk_pkg::QueueDepth];
   logic [nmea_chk_pkg::QueuePtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [nmea_chk_pkg::QueuePtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [nmea_chk_pkg::QueueCntW-1:0]         count_ff, count_in;

   assign full       = (count_ff == nmea_chk_pkg::QueueCntW'(nmea_chk_pkg::QueueDepth));
   assign not_empty  = (count_ff != '0);
   assign head_token = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

endmodule

`default_nettype wire

>>> rtl/nmea_chk_back.sv
// ----------------------------------------------------------------------------
// nmea_chk_back
// Line tracker: runs the per-line phase machine over classified bytes and
// loads the verdict into the result register at each newline.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_chk_back #(
   parameter int unsigned MAX_LINE_BYTES = 128
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    token_valid,
   input  wire nmea_chk_pkg::token_type token,
   output logic                         token_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [2:0]                   rsp_line_status,
   output logic [7:0]                   rsp_computed_sum,
   output logic [7:0]                   rsp_received_sum
);

   localparam int unsigned CntW = $clog2(MAX_LINE_BYTES + 1);

   typedef enum logic [2:0] {
      PhStart,
      PhBody,
      PhHex,
      PhTail,
      PhSkip
   } phase_type;

   phase_type        phase_ff;
   logic [7:0]       xor_ff;
   logic [7:0]       hex_ff;
   logic [1:0]       digits_ff;
   logic [CntW-1:0]  count_ff;
   logic [2:0]       error_ff;

   logic             rsp_valid_ff;
   logic [2:0]       status_ff, status_in;
   logic [7:0]       computed_ff;
   logic [7:0]       received_ff;

   logic             out_free;
   logic             do_step;
   logic             do_emit;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign token_pop = token_valid && (!token.is_newline || out_free);
   assign do_emit   = token_pop && token.is_newline;
   assign do_step   = token_pop && !token.is_newline;

   // verdict of the line at its newline
   always_comb begin
      priority if (error_ff != nmea_chk_pkg::StatusOk) begin
         status_in = error_ff;
      end else if (phase_ff == PhStart) begin
         status_in = nmea_chk_pkg::StatusNoDollar;
      end else if (phase_ff == PhBody) begin
         status_in = nmea_chk_pkg::StatusNoStar;
      end else if (digits_ff == 2'd0) begin
         status_in = nmea_chk_pkg::StatusNoHex;
      end else if (xor_ff == hex_ff) begin
         status_in = nmea_chk_pkg::StatusOk;
      end else begin
         status_in = nmea_chk_pkg::StatusMismatch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhStart;
         xor_ff       <= '0;
         hex_ff       <= '0;
         digits_ff    <= '0;
         count_ff     <= '0;
         error_ff     <= nmea_chk_pkg::StatusOk;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (do_emit) begin
            rsp_valid_ff <= 1'b1;
            status_ff    <= status_in;
            computed_ff  <= xor_ff;
            received_ff  <= hex_ff;
            phase_ff     <= PhStart;
            xor_ff       <= '0;
            hex_ff       <= '0;
            digits_ff    <= '0;
            count_ff     <= '0;
            error_ff     <= nmea_chk_pkg::StatusOk;
         end else begin
            if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
            end
            if (do_step && phase_ff != PhSkip) begin
               if (count_ff >= CntW'(MAX_LINE_BYTES)) begin
                  error_ff <= nmea_chk_pkg::StatusTooLong;
                  phase_ff <= PhSkip;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  unique case (phase_ff)
                     PhStart: begin
                        if (token.is_dollar) begin
                           phase_ff <= PhBody;
                        end else begin
                           error_ff <= nmea_chk_pkg::StatusNoDollar;
                           phase_ff <= PhSkip;
                        end
                     end
                     PhBody: begin
                        if (token.is_star) begin
                           phase_ff <= PhHex;
                        end else begin
                           xor_ff <= xor_ff ^ token.data;
                        end
                     end
                     PhHex: begin
                        if (token.is_hex) begin
                           hex_ff    <= {hex_ff[3:0], token.hex_digit};
                           digits_ff <= digits_ff + 1'b1;
                           if (digits_ff == 2'd1) begin
                              phase_ff <= PhTail;
                           end
                        end else begin
                           phase_ff <= PhTail;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_status  = status_ff;
   assign rsp_computed_sum = computed_ff;
   assign rsp_received_sum = received_ff;

endmodule

`default_nettype wire

>>> rtl/nmea_sentence_checksum_check.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check
// Checks NMEA 0183 sentence checksums on a byte stream, one verdict per line.
// ----------------------------------------------------------------------------
// Takes one text byte per request and gives one response per line, at each
// newline (byte 10): line_status (0 ok, 1 no leading dollar, 2 no star,
// 3 mismatch, 4 no hex digits, 5 too long), the XOR of the bytes between
// dollar and star, and the value of up to two hex digits after the star.
// Other bytes give no response. A line with more than MAX_LINE_BYTES bytes
// before its newline is flagged too long, which wins over every other code
// but no leading dollar. Rate: one request per cycle, sustained while
// responses are taken. A byte is classified on entry and queued in a
// four-entry queue; the line tracker takes one queued byte per cycle. A
// newline leaves the queue only when the response register is free, so a
// stalled response holds up the queue only once a newline reaches its head;
// req_stall rises when the queue is full. A newline is held in the queue and
// then in the response register. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checksum_check #(
   parameter int unsigned MAX_LINE_BYTES = 128
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // request channel
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_byte_in,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_line_status,
   output logic [7:0]      rsp_computed_sum,
   output logic [7:0]      rsp_received_sum
);

   // classified byte on its way in and at the queue head
   nmea_chk_pkg::token_type in_token;
   nmea_chk_pkg::token_type head_token;

   logic queue_full;
   logic queue_not_empty;
   logic queue_push;
   logic queue_pop;

   // the queue decides acceptance: full queue stalls the request side
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   // front: byte classification
   nmea_chk_front u_front (
      .byte_in (req_byte_in),
      .token   (in_token)
   );

   // decoupling queue
   nmea_chk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_token (in_token),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .pop        (queue_pop),
      .head_token (head_token)
   );

   // back: line tracking and response register
   nmea_chk_back #(
      .MAX_LINE_BYTES (MAX_LINE_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .token_valid      (queue_not_empty),
      .token            (head_token),
      .token_pop        (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_status  (rsp_line_status),
      .rsp_computed_sum (rsp_computed_sum),
      .rsp_received_sum (rsp_received_sum)
   );

endmodule

`default_nettype wire

>>> rtl/nmea_chk_checker.sv
// ----------------------------------------------------------------------------
// nmea_chk_checker
// Port-level checks of the sentence checksum checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_chk_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [2:0] rsp_line_status,
   input wire logic [7:0] rsp_computed_sum,
   input wire logic [7:0] rsp_received_sum
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_line_status)
         && $stable(rsp_computed_sum) && $stable(rsp_received_sum))
      else $error("stalled response changed");

   // ok means the sums agree, mismatch means they differ
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_status == nmea_chk_pkg::StatusOk)
         |-> rsp_computed_sum == rsp_received_sum)
      else $error("ok verdict with differing sums");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_status == nmea_chk_pkg::StatusMismatch)
         |-> rsp_computed_sum != rsp_received_sum)
      else $error("mismatch verdict with equal sums");

   // no leading dollar leaves both sums clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_status == nmea_chk_pkg::StatusNoDollar)
         |-> rsp_computed_sum == 8'h00 && rsp_received_sum == 8'h00)
      else $error("no-dollar verdict with nonzero sums");

   // without star or digits nothing was received
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_status == nmea_chk_pkg::StatusNoStar
         || rsp_line_status == nmea_chk_pkg::StatusNoHex)
         |-> rsp_received_sum == 8'h00)
      else $error("received sum set without hex digits");

endmodule

bind nmea_sentence_checksum_check nmea_chk_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_line_status  (rsp_line_status),
   .rsp_computed_sum (rsp_computed_sum),
   .rsp_received_sum (rsp_received_sum)
);

`default_nettype wire

>>> tb/nmea_sentence_checksum_check_test.sv
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check_test
// Self-checking bench for the sentence checksum checker. Each accepted byte
// goes through a line tracker kept in the bench. The tracker predicts the
// verdict that each newline gives. Every verdict that comes back is checked
// against the oldest prediction. Directed sentences come first, then random
// sentences and noise, with random idling on both channels and a long
// response hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module nmea_sentence_checksum_check_test;

   localparam int unsigned LineLimit     = 128;
   localparam int          RandomItems   = 90;    // minimum bytes in the random part
   localparam int          MinLines      = 8;     // minimum verdicts in the random part
   localparam int          HoldOffCycles = 300;
   localparam int          DrainLimit    = 5000;
   localparam int          TailCycles    = 40;
   localparam logic [7:0]  CharReturn    = 8'h0d;

   // tracker phase within one line
   typedef enum logic [2:0] {
      PhaseStart,
      PhaseBody,
      PhaseHex,
      PhaseTail,
      PhaseSkip
   } line_phase_type;

   typedef struct packed {
      logic [2:0] line_status;
      logic [7:0] computed_sum;
      logic [7:0] received_sum;
   } verdict_type;

   // line tracker and the queue of verdicts that are still to come
   class verdict_scoreboard;
      verdict_type    expected_q[$];
      int             failures;
      line_phase_type phase;
      logic [7:0]     xor_acc;
      logic [7:0]     hex_acc;
      logic [1:0]     digits;
      logic [7:0]     count;
      logic [2:0]     err;

      function new();
         failures = 0;
         clear_line();
      endfunction

      function void clear_line();
         phase   = PhaseStart;
         xor_acc = 8'h00;
         hex_acc = 8'h00;
         digits  = 2'd0;
         count   = 8'd0;
         err     = nmea_chk_pkg::StatusOk;
      endfunction

      // 0..15 for a hex digit, bit 4 set otherwise
      function logic [4:0] hex_of(logic [7:0] c);
         if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
         if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return {1'b0, c[3:0] + 4'd9};
         return 5'h10;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [7:0] b);
         logic [4:0]  d;
         verdict_type v;
         if (b == nmea_chk_pkg::CharNewline) begin
            if (err != nmea_chk_pkg::StatusOk) v.line_status = err;
            else if (phase == PhaseStart) v.line_status = nmea_chk_pkg::StatusNoDollar;
            else if (phase == PhaseBody) v.line_status = nmea_chk_pkg::StatusNoStar;
            else if (digits == 2'd0) v.line_status = nmea_chk_pkg::StatusNoHex;
            else if (xor_acc == hex_acc) v.line_status = nmea_chk_pkg::StatusOk;
            else v.line_status = nmea_chk_pkg::StatusMismatch;
            v.computed_sum = xor_acc;
            v.received_sum = hex_acc;
            expected_q.push_back(v);
            clear_line();
            return;
         end
         if (phase == PhaseSkip) return;
         // bytes past the limit are dropped, sums stay as they were
         if (count >= LineLimit) begin
            err   = nmea_chk_pkg::StatusTooLong;
            phase = PhaseSkip;
            return;
         end
         count++;
         case (phase)
            PhaseStart: begin
               if (b == nmea_chk_pkg::CharDollar) phase = PhaseBody;
               else begin
                  err   = nmea_chk_pkg::StatusNoDollar;
                  phase = PhaseSkip;
               end
            end
            PhaseBody: begin
               if (b == nmea_chk_pkg::CharStar) phase = PhaseHex;
               else xor_acc ^= b;
            end
            PhaseHex: begin
               d = hex_of(b);
               if (!d[4]) begin
                  hex_acc = {hex_acc[3:0], d[3:0]};
                  digits++;
                  if (digits >= 2'd2) phase = PhaseTail;
               end else begin
                  phase = PhaseTail;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(logic [2:0] st, logic [7:0] cs, logic [7:0] rs);
         verdict_type v;
         if (expected_q.size() == 0) begin
            $error("response with nothing expected: line_status %0d computed_sum %h received_sum %h",
                   st, cs, rs);
            failures++;
            return;
         end
         v = expected_q.pop_front();
         if (st !== v.line_status) begin
            $error("line_status expected %0d actual %0d", v.line_status, st);
            failures++;
         end
         if (cs !== v.computed_sum) begin
            $error("computed_sum expected %h actual %h", v.computed_sum, cs);
            failures++;
         end
         if (rs !== v.received_sum) begin
            $error("received_sum expected %h actual %h", v.received_sum, rs);
            failures++;
         end
      endfunction
   endclass

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // block ports; the inputs are known from time zero
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_byte_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [2:0] rsp_line_status;
   logic [7:0] rsp_computed_sum;
   logic [7:0] rsp_received_sum;

   nmea_sentence_checksum_check #(
      .MAX_LINE_BYTES(LineLimit)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_status (rsp_line_status),
      .rsp_computed_sum(rsp_computed_sum),
      .rsp_received_sum(rsp_received_sum)
   );

   verdict_scoreboard sb;

   logic [7:0] line_buf[$];      // bytes of the line being built
   bit         send_fast     = 1'b0;
   bit         rsp_fast      = 1'b0;
   bit         hold_off_req  = 1'b0;
   int         burst_left    = 0;
   int         bytes_sent    = 0;
   int         lines_done    = 0;

   // hard limit on the whole run
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // response monitor: signals are settled at the falling edge, so what is
   // seen here is what the next rising edge accepts
   always @(negedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_line_status, rsp_computed_sum, rsp_received_sum);
   end

   // response side: random stall before each response, plus one long
   // hold-off on demand so that the queue fills and the request side stalls
   initial begin
      int gap;
      bit took;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            if ($urandom_range(0, 31) == 0) rsp_fast = !rsp_fast;
            gap = rsp_fast ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            do begin
               @(negedge clock);
               took = rsp_valid;
               @(posedge clock);
            end while (!took && !hold_off_req);
         end
      end
   end

   // one request; valid stays high across back-to-back requests so it is
   // never lowered and raised in the same step
   task automatic send_byte(input logic [7:0] b);
      int gap;
      bit took;
      gap = (send_fast || burst_left > 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      do begin
         @(negedge clock);
         took = !req_stall;
         if (took) sb.note_request(b);
         @(posedge clock);
      end while (!took);
      bytes_sent++;
   endtask

   task automatic push(input logic [7:0] b);
      line_buf.push_back(b);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endtask

   // close the line with a newline and send it
   task automatic finish_line();
      line_buf.push_back(nmea_chk_pkg::CharNewline);
      foreach (line_buf[i]) send_byte(line_buf[i]);
      line_buf.delete();
      lines_done++;
      if (burst_left > 0) burst_left--;
   endtask

   // sender idle until every verdict is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
      if (n < 4'd10) return 8'h30 + n;
      return (upper ? 8'h41 : 8'h61) + (n - 4'd10);
   endfunction

   // any byte but newline and star, mostly printable
   function automatic logic [7:0] rand_body_byte();
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 3) == 0) b = 8'($urandom_range(0, 255));
         else b = 8'($urandom_range(8'h20, 8'h7e));
      end while (b == nmea_chk_pkg::CharNewline || b == nmea_chk_pkg::CharStar);
      return b;
   endfunction

   // junk after the checksum; the block reads a hex byte in it as a digit while one is due
   task automatic add_tail();
      case ($urandom_range(0, 3))
         0: ;
         1: push(CharReturn);
         2: begin
            push(nmea_chk_pkg::CharStar);
            push(rand_body_byte());
         end
         default: repeat ($urandom_range(1, 3)) push(rand_body_byte());
      endcase
   endtask

   // dollar, body, star, then zero to two hex digits of the true or a
   // corrupted sum
   task automatic build_sentence(input int body_len, input int digits, input bit corrupt,
                                 input bit tail);
      logic [7:0] xs;
      logic [7:0] b;
      logic [7:0] val;
      push(nmea_chk_pkg::CharDollar);
      xs = 8'h00;
      repeat (body_len) begin
         b = rand_body_byte();
         push(b);
         xs ^= b;
      end
      push(nmea_chk_pkg::CharStar);
      val = corrupt ? xs ^ 8'($urandom_range(1, 255)) : xs;
      if (digits >= 2) push(hex_char(val[7:4], 1'($urandom_range(0, 1))));
      if (digits >= 1) push(hex_char(val[3:0], 1'($urandom_range(0, 1))));
      // 'g' and above holds no hex digit
      if (digits == 0 && $urandom_range(0, 1)) push(8'($urandom_range(8'h67, 8'hff)));
      if (tail) add_tail();
      finish_line();
   endtask

   function automatic int rand_body_len();
      return ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
   endfunction

   initial begin
      int kind;
      int line_no;
      int waited;
      logic [7:0] b;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed sentences ----
      finish_line();                                   // empty line
      push_text("A$*00"); finish_line();               // first byte not dollar
      push(8'hff); push_text("$*"); finish_line();
      push_text("$"); finish_line();                   // no star, empty body
      push_text("$AB"); finish_line();                 // no star
      push_text("$*"); finish_line();                  // star with no hex
      push_text("$A*G1"); finish_line();               // non-hex right after star
      push_text("$12*3"); finish_line();               // one digit, matches
      push_text("$12*4"); finish_line();               // one digit, mismatch
      push_text("$A*40"); finish_line();               // two digits, mismatch
      push_text("$j*6a"); finish_line();               // lower case digits
      push_text("$J*4A"); push(CharReturn); finish_line();
      push_text("$A$B*27"); finish_line();             // second dollar is body
      push_text("$A*41*ZZ"); push(CharReturn); finish_line();
      push(nmea_chk_pkg::CharDollar); push(8'h00); push(8'hff); push_text("*FF");
      finish_line();
      build_sentence(6, 2, 1'b0, 1'b0);
      build_sentence(LineLimit - 4, 2, 1'b0, 1'b0);    // exactly at the limit
      build_sentence(LineLimit - 3, 2, 1'b0, 1'b0);    // one byte too many
      push(nmea_chk_pkg::CharDollar);                  // no star, right at the limit
      repeat (LineLimit - 1) push("x");
      finish_line();
      repeat (LineLimit / 4) push("x");                // long text without dollar
      finish_line();
      wait_drained();

      // ---- random sentences and noise ----
      bytes_sent = 0;
      lines_done = 0;
      line_no    = 0;
      while (bytes_sent < RandomItems || lines_done < MinLines) begin
         if ($urandom_range(0, 5) == 0) send_fast = !send_fast;
         // long response hold-off while requests keep coming back to back
         if (line_no == 2) begin
            hold_off_req = 1'b1;
            burst_left   = 3;
         end
         // sender pause until every verdict is back
         if (line_no == 5) wait_drained();
         kind = $urandom_range(0, 99);
         if (kind < 55) begin
            build_sentence(rand_body_len(), 2, 1'b0, 1'($urandom_range(0, 1)));
         end else if (kind < 65) begin
            build_sentence(rand_body_len(), 2, 1'b1, 1'($urandom_range(0, 1)));
         end else if (kind < 70) begin
            build_sentence(rand_body_len(), 1, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
         end else if (kind < 75) begin
            build_sentence(rand_body_len(), 0, 1'b0, 1'($urandom_range(0, 1)));
         end else if (kind < 80) begin
            // no star
            push(nmea_chk_pkg::CharDollar);
            repeat (rand_body_len()) push(rand_body_byte());
            finish_line();
         end else if (kind < 85) begin
            // first byte anything but dollar or newline
            do b = 8'($urandom_range(0, 255));
            while (b == nmea_chk_pkg::CharDollar || b == nmea_chk_pkg::CharNewline);
            push(b);
            repeat (rand_body_len()) push(rand_body_byte());
            finish_line();
         end else if (kind < 90) begin
            // raw noise, newlines included
            repeat ($urandom_range(1, 10)) push(8'($urandom_range(0, 255)));
            finish_line();
         end else if (kind < 93) begin
            build_sentence(LineLimit - 4 + $urandom_range(0, 12), 2, 1'b0, 1'b0);
         end else begin
            if ($urandom_range(0, 1)) push(nmea_chk_pkg::CharDollar);
            finish_line();
         end
         line_no++;
      end
      req_valid <= 1'b0;

      // ---- drain ----
      waited = 0;
      while (sb.pending() != 0 && waited < DrainLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (TailCycles) @(posedge clock);
      if (sb.pending() != 0)
         $error("%0d expected responses never arrived", sb.pending());

      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> nmea_sentence_checksum_check.f
rtl/nmea_chk_pkg.sv
rtl/nmea_chk_front.sv
rtl/nmea_chk_queue.sv
rtl/nmea_chk_back.sv
rtl/nmea_sentence_checksum_check.sv
rtl/nmea_chk_checker.sv
tb/nmea_sentence_checksum_check_test.sv
